>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SGW_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SGW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sgw_pkg.sv
package sgw_pkg;

	localparam int SEGMENTS     = 16;
	localparam int SEG_IDX_W    = $clog2(SEGMENTS);
	localparam int SEG_CNT_W    = $clog2(SEGMENTS + 1);
	localparam int LENGTH_BITS  = 32;
	localparam int ADDRESS_BITS = 64;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_APPEND   = 2'd1,
		OP_TRANSFER = 2'd2,
		OP_FORWARD  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_TRANSFER,
		BK_FORWARD
	} back_state_t;

	typedef struct packed {
		op_t                     op;
		logic [ADDRESS_BITS-1:0] address;
		logic [LENGTH_BITS-1:0]  byte_count;
	} sgw_item_t;

endpackage

>>> rtl/sgw_front.sv
module sgw_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [1:0]                       s_axis_tuser,
	input  logic [sgw_pkg::ADDRESS_BITS-1:0] s_address,
	input  logic [sgw_pkg::LENGTH_BITS-1:0]  s_byte_count,
	output logic                             item_valid,
	output sgw_pkg::sgw_item_t               item,
	input  logic                             item_ready
);

	logic               valid_s1;
	sgw_pkg::sgw_item_t item_s1;

	// input stage can take a new item whenever it is empty or the queue takes its item
	assign s_axis_tready = !valid_s1 || item_ready;
	assign item_valid    = valid_s1;
	assign item          = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.op         <= sgw_pkg::op_t'(s_axis_tuser);
			item_s1.address    <= s_address;
			item_s1.byte_count <= s_byte_count;
		end
	end

endmodule

>>> rtl/sgw_queue.sv
`include "assert_macros.svh"

module sgw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  sgw_pkg::sgw_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output sgw_pkg::sgw_item_t pop_item
);

	sgw_pkg::sgw_item_t                entry_q [sgw_pkg::QUEUE_DEPTH];
	logic [sgw_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [sgw_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [sgw_pkg::QCNT_W-1:0]        cnt_q;
	logic                              push;
	logic                              pop;

	assign push_ready = cnt_q < sgw_pkg::QCNT_W'(sgw_pkg::QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers wrap on their own since the depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	`SGW_ASSERT(a_q_cnt_bound, clk, arst_n, 1'b1, cnt_q <= sgw_pkg::QCNT_W'(sgw_pkg::QUEUE_DEPTH), "queue holds more than its depth")
	`SGW_ASSERT_NEXT(a_q_pop_only, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "queue count wrong after pop")
	`SGW_ASSERT_NEXT(a_q_push_only, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count wrong after push")

endmodule

>>> rtl/sgw_back.sv
`include "assert_macros.svh"

module sgw_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_pop,
	input  sgw_pkg::sgw_item_t               q_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sgw_pkg::ADDRESS_BITS-1:0] out_segment_address,
	output logic [sgw_pkg::ADDRESS_BITS-1:0] out_buffer_address,
	output logic [sgw_pkg::LENGTH_BITS-1:0]  out_chunk_length,
	output logic [sgw_pkg::LENGTH_BITS-1:0]  out_bytes_left,
	output sgw_pkg::status_t                 out_status,
	output logic                             out_last
);

	localparam int AW = sgw_pkg::ADDRESS_BITS;
	localparam int LW = sgw_pkg::LENGTH_BITS;

	sgw_pkg::back_state_t state_q, state_d;

	logic [AW-1:0]                 base_tab_q [sgw_pkg::SEGMENTS];
	logic [LW-1:0]                 len_tab_q  [sgw_pkg::SEGMENTS];
	logic [sgw_pkg::SEG_CNT_W-1:0] seg_cnt_q;
	logic [sgw_pkg::SEG_CNT_W-1:0] cur_seg_q;
	logic [LW-1:0]                 offset_q;
	logic [LW-1:0]                 rem_q;
	logic [LW-1:0]                 want_q;
	logic [AW-1:0]                 buf_q;

	logic                          out_valid_q;
	logic [AW-1:0]                 out_seg_q, out_buf_q;
	logic [LW-1:0]                 out_len_q, out_left_q;
	sgw_pkg::status_t              out_status_q;
	logic                          out_last_q;

	logic                          step;
	logic [sgw_pkg::SEG_IDX_W-1:0] cur_idx;
	logic                          in_table;
	logic [LW-1:0]                 left;
	logic [LW-1:0]                 take;
	logic [LW-1:0]                 rem_after;
	logic [LW-1:0]                 want_after;
	logic                          chunk_last;
	logic [LW:0]                   append_sum;
	logic                          table_full;
	logic                          xfer_empty;
	logic                          fwd_done;

	logic                          do_clear, do_append, do_start, do_advance, do_chunk;
	logic                          out_load;
	logic [AW-1:0]                 out_seg_d, out_buf_d;
	logic [LW-1:0]                 out_len_d, out_left_d;
	sgw_pkg::status_t              out_status_d;
	logic                          out_last_d;

	// a step may run when the output register is free or draining this cycle
	assign step       = !out_valid_q || out_ready;
	assign cur_idx    = cur_seg_q[sgw_pkg::SEG_IDX_W-1:0];
	assign in_table   = cur_seg_q < seg_cnt_q;
	assign left       = in_table ? len_tab_q[cur_idx] - offset_q : '0;
	assign take       = (want_q < left) ? want_q : left;
	assign rem_after  = (rem_q >= take) ? rem_q - take : '0;
	assign want_after = want_q - take;
	assign chunk_last = (want_after == '0) || (rem_after == '0);
	assign append_sum = {1'b0, rem_q} + {1'b0, q_item.byte_count};
	assign table_full = seg_cnt_q >= sgw_pkg::SEG_CNT_W'(sgw_pkg::SEGMENTS);
	assign xfer_empty = (want_q == '0) || (rem_q == '0);
	assign fwd_done   = (want_q == '0) || !in_table;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sgw_pkg::BK_IDLE: begin
				if (q_valid && step) begin
					if (q_item.op == sgw_pkg::OP_TRANSFER) begin
						state_d = sgw_pkg::BK_TRANSFER;
					end else if (q_item.op == sgw_pkg::OP_FORWARD) begin
						state_d = sgw_pkg::BK_FORWARD;
					end
				end
			end
			sgw_pkg::BK_TRANSFER: begin
				if (step && (xfer_empty || (left != '0 && chunk_last))) begin
					state_d = sgw_pkg::BK_IDLE;
				end
			end
			sgw_pkg::BK_FORWARD: begin
				if (step && fwd_done) begin
					state_d = sgw_pkg::BK_IDLE;
				end
			end
			default: state_d = sgw_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop        = 1'b0;
		do_clear     = 1'b0;
		do_append    = 1'b0;
		do_start     = 1'b0;
		do_advance   = 1'b0;
		do_chunk     = 1'b0;
		out_load     = 1'b0;
		out_seg_d    = '0;
		out_buf_d    = '0;
		out_len_d    = '0;
		out_left_d   = rem_q;
		out_status_d = sgw_pkg::ST_OK;
		out_last_d   = 1'b1;
		case (state_q)
			sgw_pkg::BK_IDLE: begin
				if (q_valid && step) begin
					q_pop = 1'b1;
					case (q_item.op)
						sgw_pkg::OP_CLEAR: begin
							do_clear   = 1'b1;
							out_load   = 1'b1;
							out_left_d = '0;
						end
						sgw_pkg::OP_APPEND: begin
							out_load = 1'b1;
							if (table_full) begin
								out_status_d = sgw_pkg::ST_FULL;
							end else if (append_sum[LW]) begin
								out_status_d = sgw_pkg::ST_OVERFLOW;
							end else begin
								do_append  = 1'b1;
								out_left_d = append_sum[LW-1:0];
							end
						end
						sgw_pkg::OP_TRANSFER: do_start = 1'b1;
						sgw_pkg::OP_FORWARD:  do_start = 1'b1;
						default: ;
					endcase
				end
			end
			sgw_pkg::BK_TRANSFER: begin
				if (step) begin
					if (xfer_empty) begin
						// nothing moved: single empty result
						out_load = 1'b1;
					end else begin
						do_advance = 1'b1;
						// zero-length segments are stepped over silently
						if (left != '0) begin
							do_chunk   = 1'b1;
							out_load   = 1'b1;
							out_seg_d  = base_tab_q[cur_idx] + AW'(offset_q);
							out_buf_d  = buf_q;
							out_len_d  = take;
							out_left_d = rem_after;
							out_last_d = chunk_last;
						end
					end
				end
			end
			sgw_pkg::BK_FORWARD: begin
				if (step) begin
					if (fwd_done) begin
						out_load = 1'b1;
					end else begin
						do_advance = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sgw_pkg::BK_IDLE;
			seg_cnt_q <= '0;
			cur_seg_q <= '0;
			offset_q  <= '0;
			rem_q     <= '0;
		end else begin
			state_q <= state_d;
			if (do_clear) begin
				seg_cnt_q <= '0;
				cur_seg_q <= '0;
				offset_q  <= '0;
				rem_q     <= '0;
			end else if (do_append) begin
				seg_cnt_q <= seg_cnt_q + 1'b1;
				rem_q     <= append_sum[LW-1:0];
			end else if (do_advance) begin
				rem_q <= rem_after;
				if (take == left) begin
					cur_seg_q <= cur_seg_q + 1'b1;
					offset_q  <= '0;
				end else begin
					offset_q <= offset_q + take;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_append) begin
			base_tab_q[seg_cnt_q[sgw_pkg::SEG_IDX_W-1:0]] <= q_item.address;
			len_tab_q[seg_cnt_q[sgw_pkg::SEG_IDX_W-1:0]]  <= q_item.byte_count;
		end
		if (do_start) begin
			want_q <= q_item.byte_count;
			buf_q  <= q_item.address;
		end else if (do_advance) begin
			want_q <= want_after;
			if (do_chunk) begin
				buf_q <= buf_q + AW'(take);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_seg_q    <= out_seg_d;
			out_buf_q    <= out_buf_d;
			out_len_q    <= out_len_d;
			out_left_q   <= out_left_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
		end
	end

	assign out_valid           = out_valid_q;
	assign out_segment_address = out_seg_q;
	assign out_buffer_address  = out_buf_q;
	assign out_chunk_length    = out_len_q;
	assign out_bytes_left      = out_left_q;
	assign out_status          = out_status_q;
	assign out_last            = out_last_q;

	`SGW_ASSERT(a_cur_in_range, clk, arst_n, 1'b1, cur_seg_q <= seg_cnt_q, "walk position beyond table")
	`SGW_ASSERT(a_end_no_bytes, clk, arst_n, cur_seg_q == seg_cnt_q, rem_q == '0, "bytes left at end of table")
	`SGW_ASSERT(a_mid_chunk_nonzero, clk, arst_n, do_chunk && !out_last_d, out_len_d != '0, "empty chunk not marked last")
	`SGW_ASSERT(a_load_needs_room, clk, arst_n, out_load, step, "result loaded over a held one")

endmodule

>>> rtl/scatter_gather_chunk_walker.sv
// scatter-gather chunk walker
// input stream: s_axis_tuser carries the item kind (clear, append, transfer,
// forward), s_axis_tdata the address and byte count. output stream: one
// transaction per result; m_axis_tuser carries the status, m_axis_tlast marks
// the final result of an input item, m_axis_tdata the chunk fields.
// an item passes an input register and a two-entry queue before the walker,
// which loads a transfer before its first chunk. clear and append are handled
// in the idle state, each giving a single result. a transfer is loaded, then
// the walker visits one segment per step (zero-length segments included) and
// gives a chunk on each step but on zero-length segments; an empty transfer is
// loaded and then gives a single empty result. a forward is loaded, steps
// through the segments it visits and then gives its result. the walker steps
// once per cycle through the segment table while the result register is free
// or draining. reset empties the table and the walk position; no clearing
// pass is needed.
// when the receiver stalls the result register holds and the walker waits; the
// input side fills the queue, then its input register, then drops tready.
module scatter_gather_chunk_walker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // address[63:0], byte_count[95:64]
	input  logic [1:0]   s_axis_tuser,  // mode[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// segment_address[63:0], buffer_address[127:64], chunk_length[159:128],
	// bytes_left[191:160]
	output logic [191:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,  // status[1:0]
	output logic         m_axis_tlast
);

	logic               fr_valid, fr_ready;
	sgw_pkg::sgw_item_t fr_item;
	logic               q_valid, q_pop;
	sgw_pkg::sgw_item_t q_item;
	logic [63:0]        seg_addr, buf_addr;
	logic [31:0]        chunk_len, bytes_left;
	sgw_pkg::status_t   status;

	sgw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_address     (s_axis_tdata[63:0]),
		.s_byte_count  (s_axis_tdata[95:64]),
		.item_valid    (fr_valid),
		.item          (fr_item),
		.item_ready    (fr_ready)
	);

	sgw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_item   (q_item)
	);

	sgw_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.q_valid             (q_valid),
		.q_pop               (q_pop),
		.q_item              (q_item),
		.out_valid           (m_axis_tvalid),
		.out_ready           (m_axis_tready),
		.out_segment_address (seg_addr),
		.out_buffer_address  (buf_addr),
		.out_chunk_length    (chunk_len),
		.out_bytes_left      (bytes_left),
		.out_status          (status),
		.out_last            (m_axis_tlast)
	);

	assign m_axis_tdata = {bytes_left, chunk_len, buf_addr, seg_addr};
	assign m_axis_tuser = status;

endmodule
